>>> hdl/ppp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;

  localparam int COORD_W = 32;              // Q16.16 coordinate width
  localparam int FRAC_W  = 16;              // fractional bits
  localparam int NUM_W   = 66;              // signed n.p + d in Q34.32
  localparam int MAG_W   = 64;              // magnitude of numerator and |n|^2
  localparam int QUO_W   = MAG_W + FRAC_W;  // quotient bits, one divider stage each
  localparam int Q_DEPTH = 4;               // entries between front and back
  localparam int Q_PTR_W = $clog2(Q_DEPTH);

  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic signed [COORD_W-1:0] nx;
    logic signed [COORD_W-1:0] ny;
    logic signed [COORD_W-1:0] nz;
  } ppp_geom_t;

  // Everything that rides along the divider next to the quotient
  typedef struct packed {
    logic [MAG_W-1:0] den;
    logic             neg;
    logic             degen;
    ppp_geom_t        geom;
  } ppp_ctx_t;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    ppp_ctx_t         ctx;
  } ppp_work_t;

endpackage
`default_nettype wire

>>> hdl/ppp_front.sv
`timescale 1ns / 1ps
`default_nettype none
module ppp_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [7*ppp_pkg::COORD_W-1:0] in_tdata,
  input  wire logic                         q_full,
  output logic                              push,
  output ppp_pkg::ppp_work_t                push_data
);

  localparam int CW = ppp_pkg::COORD_W;
  localparam int PW = 2 * CW;

  logic signed [CW-1:0] px, py, pz, nx, ny, nz, dd;
  logic adv;

  logic                 f1_v_r, f2_v_r, f3_v_r;
  ppp_pkg::ppp_geom_t   f1_geom_r, f2_geom_r;
  logic signed [CW-1:0] f1_d_r;
  logic signed [PW-1:0] f1_dx_r, f1_dy_r, f1_dz_r;
  logic [PW-1:0]        f1_sx_r, f1_sy_r, f1_sz_r;
  logic signed [ppp_pkg::NUM_W-1:0] f2_num_r;
  logic [ppp_pkg::MAG_W-1:0]        f2_den_r;
  ppp_pkg::ppp_work_t   f3_r;

  // Unpack the transaction
  assign px = in_tdata[0*CW +: CW];
  assign py = in_tdata[1*CW +: CW];
  assign pz = in_tdata[2*CW +: CW];
  assign nx = in_tdata[3*CW +: CW];
  assign ny = in_tdata[4*CW +: CW];
  assign nz = in_tdata[5*CW +: CW];
  assign dd = in_tdata[6*CW +: CW];

  // Advance the whole front unless the last stage cannot push
  assign adv       = !f3_v_r || !q_full;
  assign in_tready = adv;
  assign push      = f3_v_r && !q_full;
  assign push_data = f3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
      f2_v_r <= 1'b0;
      f3_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= in_tvalid;
      f2_v_r <= f1_v_r;
      f3_v_r <= f2_v_r;
    end
  end

  // Stage 1: products for the dot product and the squared norm
  always_ff @(posedge clk) begin
    if (adv) begin
      f1_geom_r <= '{px: px, py: py, pz: pz, nx: nx, ny: ny, nz: nz};
      f1_d_r    <= dd;
      f1_dx_r   <= px * nx;
      f1_dy_r   <= py * ny;
      f1_dz_r   <= pz * nz;
      f1_sx_r   <= nx * nx;
      f1_sy_r   <= ny * ny;
      f1_sz_r   <= nz * nz;
    end
  end

  // Stage 2: sum to n.p + d and |n|^2, both exact
  always_ff @(posedge clk) begin
    if (adv) begin
      f2_geom_r <= f1_geom_r;
      f2_num_r  <= {{2{f1_dx_r[PW-1]}}, f1_dx_r} + {{2{f1_dy_r[PW-1]}}, f1_dy_r}
                 + {{2{f1_dz_r[PW-1]}}, f1_dz_r}
                 + {{(ppp_pkg::NUM_W-CW-ppp_pkg::FRAC_W){f1_d_r[CW-1]}}, f1_d_r,
                    {ppp_pkg::FRAC_W{1'b0}}};
      f2_den_r  <= f1_sx_r + f1_sy_r + f1_sz_r;
    end
  end

  // Stage 3: split sign and magnitude, flag a zero normal
  logic [ppp_pkg::NUM_W-1:0] num_abs;
  assign num_abs = f2_num_r[ppp_pkg::NUM_W-1] ? (~f2_num_r + 1'b1) : f2_num_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      f3_r.mag       <= num_abs[ppp_pkg::MAG_W-1:0];
      f3_r.ctx.den   <= f2_den_r;
      f3_r.ctx.neg   <= f2_num_r[ppp_pkg::NUM_W-1];
      f3_r.ctx.degen <= (f2_den_r == '0);
      f3_r.ctx.geom  <= f2_geom_r;
    end
  end

endmodule
`default_nettype wire

>>> hdl/ppp_queue.sv
`timescale 1ns / 1ps
`default_nettype none
module ppp_queue (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  ppp_pkg::ppp_work_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               empty,
  output ppp_pkg::ppp_work_t head
);

  ppp_pkg::ppp_work_t              entry_r [ppp_pkg::Q_DEPTH];
  logic [ppp_pkg::Q_PTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [ppp_pkg::Q_PTR_W:0]       count_r;

  assign full  = (count_r == (ppp_pkg::Q_PTR_W+1)'(ppp_pkg::Q_DEPTH));
  assign empty = (count_r == '0);
  assign head  = entry_r[rd_ptr_r];

  // Store on push
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/ppp_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ppp_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       en,
  input  wire logic                       in_valid,
  input  ppp_pkg::ppp_work_t              in_work,
  output logic                            out_valid,
  output logic [ppp_pkg::QUO_W-1:0]       out_quo,
  output ppp_pkg::ppp_ctx_t               out_ctx
);

  localparam int QW = ppp_pkg::QUO_W;
  localparam int MW = ppp_pkg::MAG_W;

  logic                v_r   [QW+1];
  logic [MW-1:0]       rem_r [QW+1];
  logic [QW-1:0]       dq_r  [QW+1];
  ppp_pkg::ppp_ctx_t   ctx_r [QW+1];

  // Load: dividend is the magnitude scaled by 2^16
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= '0;
      dq_r[0]  <= {in_work.mag, {ppp_pkg::FRAC_W{1'b0}}};
      ctx_r[0] <= in_work.ctx;
    end
  end

  // One restoring step per stage: shift in a dividend bit, try subtract
  for (genvar k = 1; k <= QW; k++) begin : g_stage
    logic [MW:0] trial;
    logic [MW:0] diff;
    logic        ge;

    assign trial = {rem_r[k-1], dq_r[k-1][QW-1]};
    assign diff  = trial - {1'b0, ctx_r[k-1].den};
    assign ge    = (trial >= {1'b0, ctx_r[k-1].den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? diff[MW-1:0] : trial[MW-1:0];
        dq_r[k]  <= {dq_r[k-1][QW-2:0], ge};
        ctx_r[k] <= ctx_r[k-1];
      end
    end
  end

  assign out_valid = v_r[QW];
  assign out_quo   = dq_r[QW];
  assign out_ctx   = ctx_r[QW];

endmodule
`default_nettype wire

>>> hdl/ppp_axis.sv
`timescale 1ns / 1ps
`default_nettype none
module ppp_axis (
  input  wire logic                            clk,
  input  wire logic                            en,
  input  wire logic [ppp_pkg::QUO_W-1:0]       tmag,
  input  wire logic                            tneg,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] n,
  input  wire logic signed [ppp_pkg::COORD_W-1:0] p,
  input  wire logic                            degen,
  output logic signed [ppp_pkg::COORD_W-1:0]  proj
);

  localparam int CW   = ppp_pkg::COORD_W;
  localparam int QW   = ppp_pkg::QUO_W;
  localparam int HW   = QW - 2 * CW;           // width of the top quotient slice
  localparam int PRW  = QW + CW;               // full product width
  localparam int SHW  = PRW - ppp_pkg::FRAC_W; // after the shift
  localparam int SMW  = 62;                    // shifted magnitude kept before saturation

  logic [CW-1:0] nmag;
  logic          nneg;

  logic [2*CW-1:0]  pp0_r, pp1_r;
  logic [HW+CW-1:0] pp2_r;
  logic             s1_neg_r, s2_neg_r;
  logic signed [CW-1:0] p1_r, p2_r;
  logic [PRW-1:0]   prod;
  logic [SHW-1:0]   sh_r;

  assign nneg = n[CW-1];
  assign nmag = nneg ? (~n + 1'b1) : n;

  // Stage 1: partial products of t by |n|
  always_ff @(posedge clk) begin
    if (en) begin
      pp0_r    <= tmag[CW-1:0] * nmag;
      pp1_r    <= tmag[2*CW-1:CW] * nmag;
      pp2_r    <= tmag[QW-1:2*CW] * nmag;
      s1_neg_r <= tneg ^ nneg;
      p1_r     <= p;
    end
  end

  // Stage 2: combine, bias a negative product so the shift rounds to floor
  assign prod = {{(PRW-2*CW){1'b0}}, pp0_r}
              + {{(PRW-3*CW){1'b0}}, pp1_r, {CW{1'b0}}}
              + {pp2_r, {(2*CW){1'b0}}}
              + (s1_neg_r ? PRW'({ppp_pkg::FRAC_W{1'b1}}) : PRW'(0));

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r     <= prod[PRW-1:ppp_pkg::FRAC_W];
      s2_neg_r <= s1_neg_r;
      p2_r     <= p1_r;
    end
  end

  // Stage 3: subtract from the point and saturate
  logic [2*CW-1:0]        smag;
  logic [2*CW-1:0]        sval;
  logic signed [2*CW-1:0] diff;
  logic                   ovf;
  logic signed [CW-1:0]   res;

  assign ovf  = |sh_r[SHW-1:SMW];
  assign smag = {{(2*CW-SMW){1'b0}}, sh_r[SMW-1:0]};
  assign sval = s2_neg_r ? (~smag + 1'b1) : smag;
  assign diff = {{CW{p2_r[CW-1]}}, p2_r} - sval;

  always_comb begin
    if (degen) begin
      res = '0;
    end else if (ovf) begin
      res = s2_neg_r ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
    end else if (diff > $signed({{(CW+1){1'b0}}, {(CW-1){1'b1}}})) begin
      res = {1'b0, {(CW-1){1'b1}}};
    end else if (diff < $signed({{(CW+1){1'b1}}, {(CW-1){1'b0}}})) begin
      res = {1'b1, {(CW-1){1'b0}}};
    end else begin
      res = diff[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      proj <= res;
    end
  end

endmodule
`default_nettype wire

>>> hdl/point_plane_projection.sv
`timescale 1ns / 1ps
`default_nettype none
// Projects a point onto the plane nx*x + ny*y + nz*z + d = 0 (all Q16.16) and
// returns p - t*n with t = (n.p + d) / |n|^2 truncated toward zero, each
// coordinate saturated to 32 bits. An all-zero normal returns zeros with
// out_tuser set. One transaction is accepted per cycle while in_tready is high;
// a result passes the front stages, the queue, one divider load stage, the
// 80-stage quotient pipeline (one quotient bit per stage) and three
// multiply/saturate stages before it shows on out_tvalid. The front and the
// divider are parted by a four-entry queue, so a stall on the output side
// reaches in_tready only once the queue is full.
module point_plane_projection (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_tvalid,
  output logic                                    in_tready,
  // point_x, point_y, point_z, normal_x, normal_y, normal_z, plane_offset
  input  wire logic [7*ppp_pkg::COORD_W-1:0]      in_tdata,
  output logic                                    out_tvalid,
  input  wire logic                               out_tready,
  // proj_x, proj_y, proj_z
  output logic [3*ppp_pkg::COORD_W-1:0]           out_tdata,
  // degenerate
  output logic [0:0]                              out_tuser
);

  logic               push, q_full, q_empty, pop, adv_b;
  ppp_pkg::ppp_work_t push_data, q_head;
  logic               div_v;
  logic [ppp_pkg::QUO_W-1:0] quo;
  ppp_pkg::ppp_ctx_t  ctx;
  logic               a1_v_r, a2_v_r, out_v_r;
  logic               deg1_r, deg2_r, deg_out_r;
  logic signed [ppp_pkg::COORD_W-1:0] proj_x, proj_y, proj_z;

  ppp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  ppp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (q_head)
  );

  // Back end moves as one unless the output register holds an untaken result
  assign adv_b = !out_v_r || out_tready;
  assign pop   = adv_b && !q_empty;

  ppp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv_b),
    .in_valid  (pop),
    .in_work   (q_head),
    .out_valid (div_v),
    .out_quo   (quo),
    .out_ctx   (ctx)
  );

  ppp_axis u_axis_x (
    .clk (clk), .en (adv_b), .tmag (quo), .tneg (ctx.neg),
    .n (ctx.geom.nx), .p (ctx.geom.px), .degen (deg2_r), .proj (proj_x)
  );

  ppp_axis u_axis_y (
    .clk (clk), .en (adv_b), .tmag (quo), .tneg (ctx.neg),
    .n (ctx.geom.ny), .p (ctx.geom.py), .degen (deg2_r), .proj (proj_y)
  );

  ppp_axis u_axis_z (
    .clk (clk), .en (adv_b), .tmag (quo), .tneg (ctx.neg),
    .n (ctx.geom.nz), .p (ctx.geom.pz), .degen (deg2_r), .proj (proj_z)
  );

  // Track valid and the degenerate flag alongside the axis stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_v_r  <= 1'b0;
      a2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (adv_b) begin
      a1_v_r  <= div_v;
      a2_v_r  <= a1_v_r;
      out_v_r <= a2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_b) begin
      deg1_r    <= ctx.degen;
      deg2_r    <= deg1_r;
      deg_out_r <= deg2_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {proj_z, proj_y, proj_x};
  assign out_tuser  = deg_out_r;

endmodule
`default_nettype wire

>>> hdl/ppp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ppp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          in_tready,
  input wire logic                          out_tvalid,
  input wire logic                          out_tready,
  input wire logic [3*ppp_pkg::COORD_W-1:0] out_tdata,
  input wire logic [0:0]                    out_tuser
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  // A degenerate plane gives a zero point
  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("degenerate result not zero");

  // Reset empties the result side
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // The front is open right after reset
  a_reset_ready: assert property (@(posedge clk)
    !rst_n |=> in_tready)
    else $error("input not ready after reset");

endmodule

bind point_plane_projection ppp_checker u_ppp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
